### rtl/ompt_pkg.sv
// Package for the OSD message priority table: command codes, the request and
// response beat layouts and the beat that walks the row of table cells.
// No dependencies.
package ompt_pkg;

	// Widest index and count over the supported table depths (1 to 256)
	localparam int IDX_W = 8;
	localparam int CNT_W = 9;

	localparam logic [7:0] NO_MATCH = 8'hff;

	typedef enum logic [3:0] {
		CMD_INIT        = 4'd0,
		CMD_REGISTER    = 4'd1,
		CMD_UPDATE      = 4'd2,
		CMD_ENABLE      = 4'd3,
		CMD_ENABLE_TMO  = 4'd4,
		CMD_DISABLE     = 4'd5,
		CMD_CHECK       = 4'd6,
		CMD_PROCESS     = 4'd7,
		CMD_RELEASE_WIN = 4'd8,
		CMD_GET_DISPLAY = 4'd9
	} cmd_e;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_SMALL = 2'd1,
		MODE_FULL  = 2'd2
	} mode_e;

	typedef struct packed {
		logic [3:0]  cmd;
		logic [7:0]  msg_number;
		logic        has_short;
		logic [31:0] lifetime_ms;
		logic [31:0] now_ms;
		logic [1:0]  mode;
		logic [7:0]  window_id;
	} req_t;

	typedef struct packed {
		logic       ok;
		logic       enabled;
		logic       show_pulse;
		logic       hide_pulse;
		logic [7:0] shown_number;
		logic [4:0] shown_index;
		logic       shown_short;
		logic       displayed_valid;
		logic [7:0] displayed_number;
	} rsp_t;

	// Command beat as it travels the cell row, with the running search results
	typedef struct packed {
		logic [3:0]       cmd;
		logic [7:0]       num;
		logic             has_short;
		logic [31:0]      deadline;   // now + timeout, wrapped
		logic [31:0]      now;
		logic [1:0]       mode;
		logic [7:0]       window;
		logic [CNT_W-1:0] count;      // fill level when the beat entered
		logic             found;
		logic             enab;
		logic             pick_valid;
		logic [7:0]       best;
		logic [IDX_W-1:0] pick_idx;
	} walk_t;

endpackage

### rtl/ompt_req_if.sv
// Request channel of the OSD message priority table.
// Depends on ompt_pkg.
interface ompt_req_if import ompt_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/ompt_rsp_if.sv
// Response channel of the OSD message priority table.
// Depends on ompt_pkg.
interface ompt_rsp_if import ompt_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/ompt_cell.sv
// One table entry of the OSD message priority table: holds the entry and
// handles the command beat passing by, then hands it on. Depends on ompt_pkg.
module ompt_cell import ompt_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	input  walk_t up_beat,
	output logic  dn_valid,
	output walk_t dn_beat
);

	logic [7:0]  number_q;
	logic        short_q;
	logic        enabled_q;
	logic [31:0] deadline_q;
	logic        dn_valid_q;
	walk_t       dn_beat_q;

	logic        live;
	logic        hit;
	logic        elig;
	logic        wr_entry;
	logic        enabled_d;
	logic [31:0] deadline_d;
	walk_t       beat_d;

	assign live = up_beat.count > CNT_W'(IDX);
	assign hit  = live && !up_beat.found && (up_beat.num != NO_MATCH)
		&& (number_q == up_beat.num);
	assign elig = (up_beat.mode == MODE_FULL) || ((up_beat.mode == MODE_SMALL) && short_q);

	always_comb begin
		beat_d     = up_beat;
		enabled_d  = enabled_q;
		deadline_d = deadline_q;
		wr_entry   = 1'b0;
		case (cmd_e'(up_beat.cmd))
			CMD_INIT: begin
				enabled_d  = 1'b0;
				deadline_d = '0;
			end
			CMD_REGISTER: begin
				wr_entry = up_beat.count == CNT_W'(IDX);
			end
			CMD_UPDATE: begin
				if (hit) begin
					beat_d.found = 1'b1;
				end
			end
			CMD_CHECK: begin
				if (hit) begin
					beat_d.found = 1'b1;
					beat_d.enab  = enabled_q;
				end
			end
			CMD_ENABLE, CMD_ENABLE_TMO, CMD_DISABLE: begin
				if (hit) begin
					beat_d.found = 1'b1;
					enabled_d    = cmd_e'(up_beat.cmd) != CMD_DISABLE;
					deadline_d   = (cmd_e'(up_beat.cmd) == CMD_ENABLE_TMO) ?
						up_beat.deadline : 32'd0;
				end
			end
			CMD_PROCESS: begin
				if (live && (up_beat.mode != MODE_NONE)) begin
					// pick sees the flag before expiry
					if (elig && enabled_q && (number_q < up_beat.best)) begin
						beat_d.pick_valid = 1'b1;
						beat_d.best       = number_q;
						beat_d.pick_idx   = IDX_W'(IDX);
					end
					if (enabled_q && (deadline_q != 32'd0) && (deadline_q <= up_beat.now)) begin
						enabled_d  = 1'b0;
						deadline_d = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= 1'b0;
			deadline_q <= '0;
			dn_valid_q <= 1'b0;
		end else begin
			dn_valid_q <= up_valid;
			if (up_valid) begin
				enabled_q  <= enabled_d;
				deadline_q <= deadline_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		dn_beat_q <= beat_d;
		if (up_valid && wr_entry) begin
			number_q <= up_beat.num;
			short_q  <= up_beat.has_short;
		end
	end

	assign dn_valid = dn_valid_q;
	assign dn_beat  = dn_beat_q;

endmodule

### rtl/osd_message_priority_table.sv
// OSD message priority table: top level with the cell row, fill count,
// display state and response register. Depends on ompt_pkg, ompt_req_if,
// ompt_rsp_if and ompt_cell.
//
// Usage:
//   req carries one command per beat, rsp returns exactly one result beat
//   per command. Both are valid/ready channels.
//   Every command walks the whole row of ENTRIES cells, one cell per cycle;
//   each cell owns one table entry and does its lookup, write, pick or
//   expiry as the beat passes. Lookups take the first match, picks keep the
//   lowest number seen so far (strict less, so earlier entries win ties).
//   Each request beat is registered in the entry stage, then in each of the
//   ENTRIES cells, then in the response register. One command is in flight
//   at a time; ready drops on accept and returns once the result sits in the
//   response register, so the next command waits for the walk down the row.
//   A stalled receiver does not lose the result: the response register
//   holds it, a finished walk parks in a spare register, and req stays not
//   ready until the parked result has moved on.
//   Reset clears the fill count, the enable flags, deadlines and display
//   state. Entry numbers and short flags are only read below the fill count.
module osd_message_priority_table import ompt_pkg::*; #(
	parameter int ENTRIES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	ompt_req_if.sink   req,
	ompt_rsp_if.source rsp
);

	localparam int CW = $clog2(ENTRIES + 1);

	// walk entry stage
	logic          walk_v_q;
	walk_t         walk_q;
	logic          link_v [ENTRIES+1];
	walk_t         link   [ENTRIES+1];

	logic          busy_q;
	logic [CW-1:0] entry_count_q;
	logic [7:0]    disp_window_q;
	logic [1:0]    disp_mode_q;
	logic          disp_valid_q;
	logic [7:0]    disp_number_q;

	logic          rsp_valid_q;
	rsp_t          rsp_q;
	logic          pend_valid_q;
	rsp_t          pend_q;

	logic          accept;
	logic          rsp_free;
	walk_t         ex;
	logic          ex_valid;
	rsp_t          res;
	logic          room;
	logic          changed;

	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	// entry stage: build the beat, the deadline sum is done once here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_v_q <= 1'b0;
		end else begin
			walk_v_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			walk_q.cmd        <= req.data.cmd;
			walk_q.num        <= req.data.msg_number;
			walk_q.has_short  <= req.data.has_short;
			walk_q.deadline   <= req.data.now_ms + req.data.lifetime_ms;
			walk_q.now        <= req.data.now_ms;
			walk_q.mode       <= req.data.mode;
			walk_q.window     <= req.data.window_id;
			walk_q.count      <= CNT_W'(entry_count_q);
			walk_q.found      <= 1'b0;
			walk_q.enab       <= 1'b0;
			walk_q.pick_valid <= 1'b0;
			walk_q.best       <= NO_MATCH;
			walk_q.pick_idx   <= '0;
		end
	end

	assign link_v[0] = walk_v_q;
	assign link[0]   = walk_q;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		ompt_cell #(
			.IDX(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (link_v[g]),
			.up_beat  (link[g]),
			.dn_valid (link_v[g+1]),
			.dn_beat  (link[g+1])
		);
	end

	assign ex_valid = link_v[ENTRIES];
	assign ex       = link[ENTRIES];
	assign room     = ex.count < CNT_W'(ENTRIES);
	assign changed  = (disp_window_q != ex.window) || (disp_mode_q != ex.mode)
		|| !disp_valid_q || (disp_number_q != ex.best);

	// result of the finished walk
	always_comb begin
		res = '0;
		case (cmd_e'(ex.cmd))
			CMD_INIT, CMD_RELEASE_WIN: begin
				res.ok = 1'b1;
			end
			CMD_REGISTER: begin
				res.ok = room;
			end
			CMD_UPDATE, CMD_ENABLE, CMD_ENABLE_TMO, CMD_DISABLE: begin
				res.ok = ex.found;
			end
			CMD_CHECK: begin
				res.ok      = ex.found;
				res.enabled = ex.found && ex.enab;
			end
			CMD_PROCESS: begin
				res.ok = 1'b1;
				if (ex.pick_valid) begin
					if (changed) begin
						res.show_pulse   = 1'b1;
						res.shown_number = ex.best;
						res.shown_index  = 5'(ex.pick_idx);
						res.shown_short  = ex.mode == MODE_SMALL;
					end
				end else begin
					res.hide_pulse = disp_valid_q;
				end
			end
			CMD_GET_DISPLAY: begin
				res.ok               = 1'b1;
				res.displayed_valid  = disp_valid_q;
				res.displayed_number = disp_valid_q ? disp_number_q : 8'd0;
			end
			default: begin
			end
		endcase
	end

	// fill count and display state move when the walk comes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			disp_window_q <= '0;
			disp_mode_q   <= MODE_NONE;
			disp_valid_q  <= 1'b0;
			disp_number_q <= '0;
		end else if (ex_valid) begin
			case (cmd_e'(ex.cmd))
				CMD_INIT: begin
					entry_count_q <= '0;
					disp_window_q <= '0;
					disp_mode_q   <= MODE_NONE;
					disp_valid_q  <= 1'b0;
					disp_number_q <= '0;
				end
				CMD_REGISTER: begin
					if (room) begin
						entry_count_q <= CW'(entry_count_q + 1'b1);
					end
				end
				CMD_UPDATE: begin
					if (ex.found && disp_valid_q && (disp_number_q == ex.num)) begin
						disp_valid_q <= 1'b0;
					end
				end
				CMD_PROCESS: begin
					if (ex.pick_valid) begin
						if (changed) begin
							disp_window_q <= ex.window;
							disp_mode_q   <= ex.mode;
							disp_valid_q  <= 1'b1;
							disp_number_q <= ex.best;
						end
					end else if (disp_valid_q) begin
						disp_window_q <= '0;
						disp_mode_q   <= MODE_NONE;
						disp_valid_q  <= 1'b0;
					end
				end
				CMD_RELEASE_WIN: begin
					disp_window_q <= '0;
					disp_mode_q   <= MODE_NONE;
				end
				default: begin
				end
			endcase
		end
	end

	// response register with one parking slot behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end
			if (ex_valid) begin
				if (rsp_free) begin
					rsp_valid_q <= 1'b1;
					busy_q      <= 1'b0;
				end else begin
					pend_valid_q <= 1'b1;
				end
			end else if (pend_valid_q && rsp_free) begin
				rsp_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
				busy_q       <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ex_valid) begin
			if (rsp_free) begin
				rsp_q <= res;
			end else begin
				pend_q <= res;
			end
		end else if (pend_valid_q && rsp_free) begin
			rsp_q <= pend_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule

### sim/osd_message_priority_table_tb.sv
// Self-checking testbench for osd_message_priority_table: directed and random command beats,
// a built-in table predictor, and field-by-field checks of every result beat.
// Depends on ompt_pkg, ompt_req_if, ompt_rsp_if and the RTL of osd_message_priority_table.
module osd_message_priority_table_tb;
	import ompt_pkg::*;

	localparam int ENTRIES = 32;
	// A command walks the whole row, so one walk plus margin covers any result in flight
	localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 300;
	localparam logic [1:0] MODE_RESERVED = 2'd3;
	localparam logic [3:0] CMD_FIRST_UNUSED = 4'd10;
	localparam logic [3:0] CMD_LAST_UNUSED = 4'd15;

	logic clk = 1'b0;
	logic arst_n;

	ompt_req_if req_ch ();
	ompt_rsp_if rsp_ch ();

	osd_message_priority_table #(.ENTRIES(ENTRIES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Table predictor: its own copy of the entries and the display state
	// ------------------------------------------------------------------
	logic [7:0]  tbl_num   [ENTRIES];
	logic        tbl_short [ENTRIES];
	logic        tbl_on    [ENTRIES];
	logic [31:0] tbl_due   [ENTRIES];
	int          tbl_fill;
	logic [7:0]  disp_win;
	logic [1:0]  disp_mode;
	logic        disp_on;
	logic [7:0]  disp_num;

	// Run statistics for the summary
	int cmds_accepted = 0;
	int results_checked = 0;
	int draws_seen = 0;
	int removals_seen = 0;
	int expiries_seen = 0;
	int full_rejects = 0;
	int mismatches = 0;

	function automatic void table_clear();
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_num[i] = '0;
			tbl_short[i] = 1'b0;
			tbl_on[i] = 1'b0;
			tbl_due[i] = '0;
		end
		tbl_fill = 0;
		disp_win = '0;
		disp_mode = MODE_NONE;
		disp_on = 1'b0;
		disp_num = '0;
	endfunction

	// First entry below the fill level with this number; 0xff never matches
	function automatic int table_lookup(input logic [7:0] num);
		if (num == NO_MATCH) begin
			return -1;
		end
		for (int i = 0; i < tbl_fill; i++) begin
			if (tbl_num[i] == num) begin
				return i;
			end
		end
		return -1;
	endfunction

	// Applies one command to the predicted state and returns its result beat
	function automatic rsp_t table_apply(input req_t r);
		rsp_t res;
		int idx;
		int pick;
		logic [8:0] best;
		logic elig;
		res = '0;
		case (r.cmd)
			CMD_INIT: begin
				table_clear();
				res.ok = 1'b1;
			end
			CMD_REGISTER: begin
				if (tbl_fill < ENTRIES) begin
					tbl_num[tbl_fill] = r.msg_number;
					tbl_short[tbl_fill] = r.has_short;
					tbl_fill++;
					res.ok = 1'b1;
				end else begin
					full_rejects++;
				end
			end
			CMD_UPDATE: begin
				idx = table_lookup(r.msg_number);
				if (idx >= 0) begin
					res.ok = 1'b1;
					// forces a redraw on the next process, without a hide
					if (disp_on && disp_num == r.msg_number) begin
						disp_on = 1'b0;
					end
				end
			end
			CMD_ENABLE, CMD_ENABLE_TMO, CMD_DISABLE: begin
				idx = table_lookup(r.msg_number);
				if (idx >= 0) begin
					tbl_on[idx] = (r.cmd != CMD_DISABLE);
					// deadline wraps at 32 bits; a sum of zero means no timeout
					tbl_due[idx] = (r.cmd == CMD_ENABLE_TMO) ? r.now_ms + r.lifetime_ms : '0;
					res.ok = 1'b1;
				end
			end
			CMD_CHECK: begin
				idx = table_lookup(r.msg_number);
				if (idx >= 0) begin
					res.ok = 1'b1;
					res.enabled = tbl_on[idx];
				end
			end
			CMD_PROCESS: begin
				pick = -1;
				best = {1'b0, NO_MATCH};
				if (r.mode != MODE_NONE) begin
					// strict less: earliest entry wins a tie, 0xff never wins
					for (int i = 0; i < tbl_fill; i++) begin
						elig = (r.mode == MODE_FULL) || (r.mode == MODE_SMALL && tbl_short[i]);
						if (elig && tbl_on[i] && {1'b0, tbl_num[i]} < best) begin
							best = {1'b0, tbl_num[i]};
							pick = i;
						end
					end
					// expiry after the pick, so an expiring entry may still be shown
					for (int i = 0; i < tbl_fill; i++) begin
						if (tbl_on[i] && tbl_due[i] != '0 && tbl_due[i] <= r.now_ms) begin
							tbl_on[i] = 1'b0;
							tbl_due[i] = '0;
							expiries_seen++;
						end
					end
				end
				res.ok = 1'b1;
				if (pick >= 0) begin
					if (disp_win != r.window_id || disp_mode != r.mode || !disp_on ||
					    disp_num != best[7:0]) begin
						disp_win = r.window_id;
						disp_mode = r.mode;
						disp_on = 1'b1;
						disp_num = best[7:0];
						res.show_pulse = 1'b1;
						res.shown_number = best[7:0];
						res.shown_index = pick[4:0];
						res.shown_short = (r.mode == MODE_SMALL);
						draws_seen++;
					end
				end else if (disp_on) begin
					disp_win = '0;
					disp_mode = MODE_NONE;
					disp_on = 1'b0;
					res.hide_pulse = 1'b1;
					removals_seen++;
				end
			end
			CMD_RELEASE_WIN: begin
				// keeps the displayed number, only forgets window and mode
				disp_win = '0;
				disp_mode = MODE_NONE;
				res.ok = 1'b1;
			end
			CMD_GET_DISPLAY: begin
				res.ok = 1'b1;
				if (disp_on) begin
					res.displayed_valid = 1'b1;
					res.displayed_number = disp_num;
				end
			end
			default: begin
				// unused codes: no state change, all-zero result
			end
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus store and generator shadow
	// ------------------------------------------------------------------
	req_t       cmd_backlog [$];
	rsp_t       expected_rsp [$];
	logic [7:0] known_nums [$];   // numbers registered since the last init
	logic [31:0] gen_clock;

	int req_idle_pct;
	int rsp_idle_pct;
	bit hold_armed = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	bit req_taken = 1'b0;
	int quiet_cycles = 0;

	// Queues a beat and tracks which numbers should hit a lookup
	task automatic queue_cmd(input req_t r);
		if (r.cmd == CMD_INIT) begin
			known_nums.delete();
		end else if (r.cmd == CMD_REGISTER && known_nums.size() < ENTRIES) begin
			known_nums.push_back(r.msg_number);
		end
		cmd_backlog.push_back(r);
	endtask

	task automatic directed(input logic [3:0] c, input logic [7:0] num, input logic hs,
	                        input logic [31:0] tmo, input logic [31:0] now,
	                        input logic [1:0] md, input logic [7:0] win);
		req_t r;
		r.cmd = c;
		r.msg_number = num;
		r.has_short = hs;
		r.lifetime_ms = tmo;
		r.now_ms = now;
		r.mode = md;
		r.window_id = win;
		queue_cmd(r);
	endtask

	// Every field random but cmd, which defaults to get-display; callers overwrite what the command actually uses
	function automatic req_t random_req();
		req_t r;
		r.cmd = CMD_GET_DISPLAY;
		r.msg_number = 8'($urandom);
		r.has_short = 1'($urandom);
		r.lifetime_ms = $urandom;
		r.now_ms = $urandom;
		r.mode = 2'($urandom);
		r.window_id = 8'($urandom);
		return r;
	endfunction

	// Mostly a number known to be in the table, sometimes anything
	function automatic logic [7:0] lookup_num();
		if (known_nums.size() != 0 && $urandom_range(0, 99) < 85) begin
			return known_nums[$urandom_range(0, known_nums.size() - 1)];
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// Episodes: init, a burst of registers (sometimes past full), then mixed traffic
	task automatic queue_random(input int n_items);
		int made;
		int n_reg;
		int n_ops;
		int roll;
		req_t r;
		made = 0;
		while (made < n_items) begin
			r = random_req();
			r.cmd = CMD_INIT;
			queue_cmd(r);
			made++;
			n_reg = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 36) : $urandom_range(2, 12);
			for (int k = 0; k < n_reg; k++) begin
				r = random_req();
				r.cmd = CMD_REGISTER;
				roll = $urandom_range(0, 9);
				if (roll == 0) begin
					r.msg_number = NO_MATCH;
				end else if (roll > 2) begin
					r.msg_number = 8'($urandom_range(0, 23));
				end
				queue_cmd(r);
				made++;
			end
			n_ops = $urandom_range(15, 50);
			for (int k = 0; k < n_ops; k++) begin
				// time moves forward a little per beat, with an occasional jump
				if ($urandom_range(0, 99) == 0) begin
					gen_clock = $urandom;
				end else begin
					gen_clock = gen_clock + $urandom_range(0, 25);
				end
				r = random_req();
				r.msg_number = lookup_num();
				r.now_ms = gen_clock;
				roll = $urandom_range(0, 99);
				if (roll < 2) begin
					r.cmd = CMD_INIT;
				end else if (roll < 14) begin
					r.cmd = CMD_REGISTER;
					if ($urandom_range(0, 3) != 0) begin
						r.msg_number = 8'($urandom_range(0, 23));
					end
				end else if (roll < 26) begin
					r.cmd = CMD_ENABLE;
				end else if (roll < 40) begin
					r.cmd = CMD_ENABLE_TMO;
					case ($urandom_range(0, 9))
						0: r.lifetime_ms = '0;
						1: r.lifetime_ms = -gen_clock;   // deadline wraps to zero
						2: r.lifetime_ms = $urandom;
						default: r.lifetime_ms = $urandom_range(1, 400);
					endcase
				end else if (roll < 48) begin
					r.cmd = CMD_DISABLE;
				end else if (roll < 55) begin
					r.cmd = CMD_CHECK;
				end else if (roll < 60) begin
					r.cmd = CMD_UPDATE;
				end else if (roll < 85) begin
					r.cmd = CMD_PROCESS;
					roll = $urandom_range(0, 99);
					if (roll < 45) begin
						r.mode = MODE_FULL;
					end else if (roll < 80) begin
						r.mode = MODE_SMALL;
					end else if (roll < 90) begin
						r.mode = MODE_NONE;
					end else begin
						r.mode = MODE_RESERVED;
					end
					if ($urandom_range(0, 4) != 0) begin
						r.window_id = 8'($urandom_range(0, 3));
					end
				end else if (roll < 89) begin
					r.cmd = CMD_RELEASE_WIN;
				end else if (roll < 96) begin
					r.cmd = CMD_GET_DISPLAY;
				end else begin
					r.cmd = 4'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
				end
				queue_cmd(r);
				made++;
			end
		end
	endtask

	task automatic wait_drained();
		while (cmd_backlog.size() != 0 || req_ch.valid || expected_rsp.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// ------------------------------------------------------------------
	// Request driver: changes at the falling edge, holds a beat until taken
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && !(req_ch.valid && !req_taken)) begin
			if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
				req_ch.valid <= 1'b1;
				req_ch.data <= cmd_backlog.pop_front();
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Response ready: random stalls, plus one long hold-off so the block backs up
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_armed && !hold_done) begin
				rsp_ch.ready <= 1'b0;
				hold_left <= LONG_HOLD;
				hold_done <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
	                                    input logic [31:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0h, got %0h", name, want, seen);
			mismatches++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Monitor: samples both channels at the rising edge. The result is
	// checked before the new beat is predicted, so a same-edge accept can
	// never be matched against its own expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			req_taken <= req_ch.valid && req_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsp.size() == 0) begin
					$error("result beat with no command outstanding");
					mismatches++;
				end else begin
					want = expected_rsp.pop_front();
					check_field("ok", 32'(want.ok), 32'(rsp_ch.data.ok));
					check_field("enabled", 32'(want.enabled), 32'(rsp_ch.data.enabled));
					check_field("show_pulse", 32'(want.show_pulse),
					            32'(rsp_ch.data.show_pulse));
					check_field("hide_pulse", 32'(want.hide_pulse),
					            32'(rsp_ch.data.hide_pulse));
					check_field("shown_number", 32'(want.shown_number),
					            32'(rsp_ch.data.shown_number));
					check_field("shown_index", 32'(want.shown_index),
					            32'(rsp_ch.data.shown_index));
					check_field("shown_short", 32'(want.shown_short),
					            32'(rsp_ch.data.shown_short));
					check_field("displayed_valid", 32'(want.displayed_valid),
					            32'(rsp_ch.data.displayed_valid));
					check_field("displayed_number", 32'(want.displayed_number),
					            32'(rsp_ch.data.displayed_number));
					results_checked++;
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				expected_rsp.push_back(table_apply(req_ch.data));
				cmds_accepted++;
			end
			// watchdog: too long with no beat moving on either side
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: %0d cycles with no beat, %0d results outstanding",
				         quiet_cycles, expected_rsp.size());
				$display("osd_message_priority_table verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: reset, directed beats, three random phases, drain, verdict
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		req_idle_pct = 32;
		rsp_idle_pct = 57;
		gen_clock = 32'd5000;
		table_clear();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: lookups, ties, 0xff, deadline wrap, show/hide/redraw, odd modes
		directed(CMD_GET_DISPLAY, 8'h00, 1'b0, 32'h0, 32'h0, MODE_NONE, 8'h00);
		directed(CMD_INIT, 8'hff, 1'b1, 32'hffff_ffff, 32'hffff_ffff, MODE_RESERVED, 8'hff);
		directed(CMD_REGISTER, 8'd5, 1'b1, 32'h0, 32'h0, MODE_NONE, 8'h00);
		directed(CMD_REGISTER, 8'd3, 1'b0, 32'h0, 32'h0, MODE_NONE, 8'h00);
		directed(CMD_REGISTER, 8'hff, 1'b1, 32'h0, 32'h0, MODE_NONE, 8'h00);
		directed(CMD_REGISTER, 8'd3, 1'b1, 32'h0, 32'h0, MODE_NONE, 8'h00);   // duplicate
		directed(CMD_REGISTER, 8'd0, 1'b0, 32'h0, 32'h0, MODE_NONE, 8'h00);
		directed(CMD_ENABLE, 8'd3, 1'b0, 32'h0, 32'h0, MODE_NONE, 8'h00);
		directed(CMD_ENABLE, 8'hff, 1'b0, 32'h0, 32'h0, MODE_NONE, 8'h00);   // never matches
		directed(CMD_ENABLE_TMO, 8'd5, 1'b0, 32'h10, 32'hffff_fff0, MODE_NONE, 8'h00);
		directed(CMD_CHECK, 8'd3, 1'b0, 32'h0, 32'h0, MODE_NONE, 8'h00);
		directed(CMD_CHECK, 8'd200, 1'b0, 32'h0, 32'h0, MODE_NONE, 8'h00);   // absent
		directed(CMD_PROCESS, 8'h00, 1'b0, 32'h0, 32'd100, MODE_SMALL, 8'd7);
		directed(CMD_PROCESS, 8'h00, 1'b0, 32'h0, 32'd100, MODE_SMALL, 8'd7);   // no change
		directed(CMD_PROCESS, 8'h00, 1'b0, 32'h0, 32'd100, MODE_FULL, 8'hff);
		directed(CMD_UPDATE, 8'd3, 1'b0, 32'h0, 32'h0, MODE_NONE, 8'h00);
		directed(CMD_PROCESS, 8'h00, 1'b0, 32'h0, 32'd100, MODE_FULL, 8'hff);   // redraw
		directed(CMD_ENABLE_TMO, 8'd0, 1'b0, 32'hffff_ffff, 32'd51, MODE_NONE, 8'h00);
		directed(CMD_PROCESS, 8'h00, 1'b0, 32'h0, 32'd50, MODE_FULL, 8'hff);    // picks then expires
		directed(CMD_DISABLE, 8'd3, 1'b0, 32'h0, 32'h0, MODE_NONE, 8'h00);
		directed(CMD_DISABLE, 8'd5, 1'b0, 32'h0, 32'h0, MODE_NONE, 8'h00);
		directed(CMD_PROCESS, 8'h00, 1'b0, 32'h0, 32'hffff_ffff, MODE_FULL, 8'hff);   // hide
		directed(CMD_RELEASE_WIN, 8'h00, 1'b0, 32'h0, 32'h0, MODE_NONE, 8'h00);
		directed(CMD_PROCESS, 8'h00, 1'b0, 32'h0, 32'h0, MODE_RESERVED, 8'd1);
		directed(CMD_LAST_UNUSED, 8'hff, 1'b1, 32'hffff_ffff, 32'hffff_ffff, MODE_RESERVED, 8'hff);

		// Sender sparse, receiver sparser
		queue_random(220);
		wait_drained();

		// Swapped idle rates
		req_idle_pct = 57;
		rsp_idle_pct = 32;
		queue_random(230);
		wait_drained();

		// Full rate, with one long receiver hold-off while beats keep coming
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		hold_armed = 1'b1;
		queue_random(230);
		wait_drained();

		// Catch any stray result beat
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d commands and checked %0d results: %0d draws, %0d removals,",
		         cmds_accepted, results_checked, draws_seen, removals_seen);
		$display("%0d timeouts expired, %0d registers refused by a full table, %0d mismatches",
		         expiries_seen, full_rejects, mismatches);
		if (mismatches == 0 && expected_rsp.size() == 0) begin
			$display("osd_message_priority_table verification clean");
		end else begin
			$display("osd_message_priority_table verification failed");
		end
		$finish;
	end

endmodule
